// File: rtl/lru_frame_replacer_macros.svh
// Assertion macros for the frame replacer. Each macro uses the clk and arst_n
// names visible where it is expanded.
`ifndef LRU_FRAME_REPLACER_MACROS_SVH
`define LRU_FRAME_REPLACER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LRUFR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define LRUFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define LRUFR_ASSERT_ALWAYS(lbl, cond, msg)
`define LRUFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/lrufr_pkg.sv
package lrufr_pkg;

	localparam int NUM_FRAMES = 64;
	localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
	localparam int OPC_W      = 2;
	localparam int FRAME_W    = 6;
	localparam int COUNT_W    = 7;

	typedef enum logic [OPC_W-1:0] {
		OP_PIN    = 2'd0,
		OP_UNPIN  = 2'd1,
		OP_VICTIM = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_APPLY
	} state_t;

	// Broadcast control from the sequencer to every cell of the chain.
	typedef struct packed {
		logic               shift;
		logic [IDX_W-1:0]   pos;
		logic               wr;
		logic [IDX_W-1:0]   wr_idx;
		logic [FRAME_W-1:0] frame;
	} cell_ctl_t;

endpackage

// File: rtl/lrufr_if.sv
interface lrufr_req_if import lrufr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OPC_W-1:0]   opcode;
	logic [FRAME_W-1:0] frame;

	modport source (output valid, output opcode, output frame, input ready);
	modport sink (input valid, input opcode, input frame, output ready);
endinterface

interface lrufr_rsp_if import lrufr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               victim_found;
	logic [FRAME_W-1:0] victim_frame;
	logic [COUNT_W-1:0] candidate_count;

	modport source (output valid, output victim_found, output victim_frame,
		output candidate_count, input ready);
	modport sink (input valid, input victim_found, input victim_frame,
		input candidate_count, output ready);
endinterface

// File: rtl/lru_frame_replacer.sv
// Channel  Dir  Word fields                                      Accept
// req      in   opcode[1:0], frame[5:0]                          valid & ready
// rsp      out  victim_found, victim_frame[5:0],                 valid & ready
//               candidate_count[6:0]
//
// Each word passes through accept, a compare across the cell chain that
// locates the frame, then one shift or write of the chain. A new word is taken
// while the previous result waits in the output register; the chain update
// holds until that register is free. Reset empties the candidate set at once.
`include "lru_frame_replacer_macros.svh"

module lru_frame_replacer import lrufr_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	lrufr_req_if.sink       req,
	lrufr_rsp_if.source     rsp
);

	state_t                state_q, state_d;
	logic [OPC_W-1:0]      op_q;
	logic [FRAME_W-1:0]    fr_q;
	logic [IDX_W-1:0]      pos_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [NUM_FRAMES-1:0] is_cand_q;

	logic                  rsp_valid_q;
	logic                  rsp_found_q;
	logic [FRAME_W-1:0]    rsp_frame_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	cell_ctl_t             ctl;
	logic [FRAME_W-1:0]    head_frame;
	logic [NUM_FRAMES-1:0] valid_vec;
	logic [IDX_W-1:0]      match_pos;

	logic                  in_range;
	logic                  head_in_range;
	logic [IDX_W-1:0]      fr_idx;
	logic [IDX_W-1:0]      head_idx;
	logic                  do_pin, do_unpin, do_victim;
	logic                  apply_go;
	logic                  found_d;

	lrufr_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.head_frame (head_frame),
		.valid_vec  (valid_vec),
		.match_pos  (match_pos)
	);

	assign in_range      = int'(fr_q) < NUM_FRAMES;
	assign head_in_range = int'(head_frame) < NUM_FRAMES;
	assign fr_idx        = IDX_W'(fr_q);
	assign head_idx      = IDX_W'(head_frame);

	assign do_pin    = (op_q == OP_PIN) && in_range && is_cand_q[fr_idx];
	assign do_unpin  = (op_q == OP_UNPIN) && in_range && !is_cand_q[fr_idx]
		&& (int'(count_q) < NUM_FRAMES);
	assign do_victim = (op_q == OP_VICTIM) && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		apply_go   = 1'b0;
		ctl        = '0;
		ctl.frame  = fr_q;
		count_d    = count_q;
		found_d    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				// hold the chain until the result register can take the word
				if (!rsp_valid_q || rsp.ready) begin
					apply_go   = 1'b1;
					state_d    = ST_IDLE;
					ctl.shift  = do_pin || do_victim;
					ctl.pos    = do_victim ? '0 : pos_q;
					ctl.wr     = do_unpin;
					ctl.wr_idx = IDX_W'(count_q);
					if (do_pin || do_victim) begin
						count_d = count_q - 1'b1;
					end else if (do_unpin) begin
						count_d = count_q + 1'b1;
					end
					case (op_q)
						OP_PIN, OP_UNPIN: found_d = 1'b1;
						OP_VICTIM:        found_d = do_victim;
						default:          found_d = 1'b0;
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= req.opcode;
			fr_q <= req.frame;
		end
		if (state_q == ST_FIND) begin
			pos_q <= match_pos;
		end
		if (apply_go) begin
			rsp_found_q <= found_d;
			rsp_frame_q <= do_victim ? head_frame : '0;
			rsp_count_q <= COUNT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			is_cand_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply_go) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
				if (do_pin) begin
					is_cand_q[fr_idx] <= 1'b0;
				end
				if (do_unpin) begin
					is_cand_q[fr_idx] <= 1'b1;
				end
				if (do_victim && head_in_range) begin
					is_cand_q[head_idx] <= 1'b0;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.victim_found    = rsp_found_q;
	assign rsp.victim_frame    = rsp_frame_q;
	assign rsp.candidate_count = rsp_count_q;

	`LRUFR_ASSERT_ALWAYS(a_count_bound, int'(count_q) <= NUM_FRAMES, "count above frame total")
	`LRUFR_ASSERT_ALWAYS(a_chain_fill, $countones(valid_vec) == int'(count_q), "chain fill != count")
	`LRUFR_ASSERT_ALWAYS(a_cand_fill, $countones(is_cand_q) == int'(count_q), "flags != count")
	`LRUFR_ASSERT_IMP(a_apply_done, apply_go, state_d == ST_IDLE, "apply did not finish")

endmodule

// File: rtl/lrufr_cell.sv
module lrufr_cell import lrufr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [IDX_W-1:0]   idx,
	input  logic [FRAME_W-1:0] nb_frame,
	input  logic               nb_valid,
	output logic [FRAME_W-1:0] frame,
	output logic               valid,
	output logic               match
);

	logic [FRAME_W-1:0] frame_q;
	logic               valid_q;
	logic               take_nb;
	logic               take_wr;

	assign take_nb = ctl.shift && (idx >= ctl.pos);
	assign take_wr = ctl.wr && (idx == ctl.wr_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_nb) begin
			valid_q <= nb_valid;
		end else if (take_wr) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_nb) begin
			frame_q <= nb_frame;
		end else if (take_wr) begin
			frame_q <= ctl.frame;
		end
	end

	assign frame = frame_q;
	assign valid = valid_q;
	assign match = valid_q && (frame_q == ctl.frame);

endmodule

// File: rtl/lrufr_chain.sv
module lrufr_chain import lrufr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	output logic [FRAME_W-1:0]    head_frame,
	output logic [NUM_FRAMES-1:0] valid_vec,
	output logic [IDX_W-1:0]      match_pos
);

	logic [FRAME_W-1:0]    frame_a [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] match_vec;

	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		logic [FRAME_W-1:0] nb_frame;
		logic               nb_valid;

		// The tail cell pulls in an empty slot when the chain shifts.
		if (i == NUM_FRAMES - 1) begin : g_tail
			assign nb_frame = '0;
			assign nb_valid = 1'b0;
		end else begin : g_body
			assign nb_frame = frame_a[i+1];
			assign nb_valid = valid_vec[i+1];
		end

		lrufr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.idx      (IDX_W'(i)),
			.nb_frame (nb_frame),
			.nb_valid (nb_valid),
			.frame    (frame_a[i]),
			.valid    (valid_vec[i]),
			.match    (match_vec[i])
		);
	end

	assign head_frame = frame_a[0];

	// Frames in the chain are distinct, so at most one cell matches.
	always_comb begin
		match_pos = '0;
		for (int i = 0; i < NUM_FRAMES; i++) begin
			if (match_vec[i]) begin
				match_pos = match_pos | IDX_W'(i);
			end
		end
	end

endmodule
